/* rtl/assert_macros.svh */
// Assertion macros used by pcm_frame_to_mono_s16.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/pfm_pkg.sv */
`default_nettype none

package pfm_pkg;

   localparam int BYTE_W   = 8;
   localparam int SAMPLE_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_SAMPLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT    = 2'd1;

   localparam logic [2:0] BPS_RESET   = 3'd2;
   localparam logic [1:0] CHANS_RESET = 2'd1;

   // Effective configuration seen by the datapath.
   typedef struct packed {
      logic [2:0] bytes_per_sample;   // always 1 to 4
      logic       stereo;
      logic       clear;              // a register write drops any partial frame
   } cfg_type;

   // One finished mono sample leaving the datapath.
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
   } result_type;

endpackage

`default_nettype wire

/* rtl/pcm_frame_to_mono_s16.sv */
// A completing byte's mono word is registered into the output buffer and shown on rsp_ once it reaches slot 0.
// Throughput: one byte per cycle while the output buffer has room; the frame state updates in a single register step.
// A two-word output buffer keeps req_tready high while one finished word waits.
// Reset is synchronous and active high; it restores 2 bytes per sample, mono,
// and an empty frame and output buffer.
`default_nettype none

`include "assert_macros.svh"

module pcm_frame_to_mono_s16
   import pfm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // Byte stream in.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] byte_value
   input  wire logic                  req_tuser,   // [0] frame_restart

   // Mono samples out.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,   // [15:0] mono_sample (signed)

   // Configuration writes: index 0 is bytes_per_sample, index 1 channel_count.
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type result;
   logic       room;
   logic       accept;

   // A byte is taken whenever the output buffer has a free slot, so the
   // stream keeps moving while one finished word waits downstream.
   assign req_tready = room;
   assign accept     = req_tvalid && req_tready;

   pfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Gathers bytes into channel samples, decodes each to 16 bits and, in
   // stereo, averages the pair. A word leaves only when a frame completes.
   pfm_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .accept        (accept),
      .byte_value    (req_tdata[BYTE_W-1:0]),
      .frame_restart (req_tuser),
      .result        (result)
   );

   pfm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A finished word only comes out of an accepted byte.
   `ASSERT_CLK(a_result_needs_accept, clock, reset, result.valid |-> accept)
   // A full buffer always has a word on offer.
   `ASSERT_CLK(a_full_shows_word, clock, reset, !req_tready |-> rsp_tvalid)
   // Reset empties the output buffer.
   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!rsp_tvalid && req_tready))

endmodule

`default_nettype wire

/* rtl/pfm_csr.sv */
`default_nettype none

module pfm_csr
   import pfm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   logic [2:0] bps_ff, bps_in;
   logic [1:0] chans_ff, chans_in;
   logic       hit_bps, hit_chans;
   logic [2:0] bps_eff;

   assign hit_bps   = csr_we && (csr_index == CSR_BYTES_PER_SAMPLE);
   assign hit_chans = csr_we && (csr_index == CSR_CHANNEL_COUNT);

   assign bps_in   = hit_bps   ? csr_wdata[2:0] : bps_ff;
   assign chans_in = hit_chans ? csr_wdata[1:0] : chans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff   <= BPS_RESET;
         chans_ff <= CHANS_RESET;
      end else begin
         bps_ff   <= bps_in;
         chans_ff <= chans_in;
      end
   end

   // Zero acts as one byte, five and above as four.
   always_comb begin
      case (bps_ff)
         3'd0:                 bps_eff = 3'd1;
         3'd1, 3'd2, 3'd3, 3'd4: bps_eff = bps_ff;
         default:              bps_eff = 3'd4;
      endcase
   end

   assign cfg = {bps_eff, chans_ff[1], (hit_bps || hit_chans)};

endmodule

`default_nettype wire

/* rtl/pfm_core.sv */
`default_nettype none

module pfm_core
   import pfm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] byte_value,
   input  wire logic              frame_restart,
   output result_type             result
);

   logic [2:0]                 pos_ff, pos_in;
   logic [23:0]                asm_ff, asm_in;
   logic signed [SAMPLE_W-1:0] left_ff, left_in;

   logic [3:0]                 frame_len;
   logic                       restart;
   logic [2:0]                 pos;
   logic [23:0]                asm_cur;
   logic                       ch;
   logic [2:0]                 in_sample;
   logic [31:0]                full;
   logic                       done;
   logic signed [SAMPLE_W-1:0] decoded;
   logic signed [SAMPLE_W:0]   sum;
   logic signed [SAMPLE_W:0]   sum_adj;
   logic signed [SAMPLE_W-1:0] average;

   assign frame_len = cfg.stereo ? {cfg.bytes_per_sample, 1'b0}
                                 : {1'b0, cfg.bytes_per_sample};
   assign restart   = frame_restart || ({1'b0, pos_ff} >= frame_len);
   assign pos       = restart ? 3'd0  : pos_ff;
   assign asm_cur   = restart ? 24'd0 : asm_ff;

   // Second channel once the first sample's bytes are behind us.
   assign ch        = (pos >= cfg.bytes_per_sample);
   assign in_sample = ch ? (pos - cfg.bytes_per_sample) : pos;

   // The last byte of a sample never needs storing, so 24 bits suffice.
   assign full = {8'd0, asm_cur} | ({24'd0, byte_value} << {in_sample[1:0], 3'b000});
   assign done = ({1'b0, in_sample} + 4'd1) >= {1'b0, cfg.bytes_per_sample};

   always_comb begin
      case (cfg.bytes_per_sample)
         3'd1:    decoded = {~full[7], full[6:0], 8'h00};
         3'd2:    decoded = full[15:0];
         3'd3:    decoded = full[23:8];
         default: decoded = full[31:16];
      endcase
   end

   // Halve with truncation toward zero: odd negative sums get one added first.
   assign sum     = {left_ff[SAMPLE_W-1], left_ff} + {decoded[SAMPLE_W-1], decoded};
   assign sum_adj = sum + {{SAMPLE_W{1'b0}}, (sum[SAMPLE_W] & sum[0])};
   assign average = sum_adj[SAMPLE_W:1];

   always_comb begin
      pos_in  = pos_ff;
      asm_in  = asm_ff;
      left_in = left_ff;
      result.valid  = 1'b0;
      result.sample = cfg.stereo ? average : decoded;
      if (cfg.clear) begin
         pos_in = 3'd0;
         asm_in = 24'd0;
      end else if (accept) begin
         if (!done) begin
            pos_in = pos + 3'd1;
            asm_in = full[23:0];
         end else begin
            asm_in = 24'd0;
            if (cfg.stereo && !ch) begin
               left_in = decoded;
               pos_in  = pos + 3'd1;
            end else begin
               pos_in       = 3'd0;
               result.valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 3'd0;
         asm_ff  <= 24'd0;
         left_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         asm_ff  <= asm_in;
         left_ff <= left_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/pfm_out.sv */
`default_nettype none

module pfm_out
   import pfm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  result_type               result,
   output logic                     room,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [SAMPLE_W-1:0]      rsp_tdata
);

   // Two-entry buffer: slot 0 is presented, slot 1 catches a word made
   // while slot 0 is stalled.
   logic [1:0]          count_ff, count_in;
   logic [SAMPLE_W-1:0] slot0_ff, slot1_ff;
   logic                pop;
   logic                push;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = slot0_ff;
   assign room       = (count_ff != 2'd2);
   assign pop        = rsp_tvalid && rsp_tready;
   assign push       = result.valid;
   assign count_in   = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (count_ff == 2'd2)) begin
         slot0_ff <= slot1_ff;
      end
      if (push) begin
         if ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop)) begin
            slot0_ff <= result.sample;
         end else begin
            slot1_ff <= result.sample;
         end
      end
   end

endmodule

`default_nettype wire
